/* src/sas_pkg.sv */
// shared types and constants for the stepper angle step sequencer
package sas_pkg;

  localparam int ANGLE_BITS_DEF = 31;
  localparam int TICK_BITS_DEF  = 8;

  localparam int STEP_ANGLE_W = 19;
  localparam int TICK_PER_W   = 8;
  localparam int STEP_CNT_W   = 16;
  localparam int STEPS_W      = 32;
  localparam int COIL_W       = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = STEP_ANGLE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_PER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 2'd2;

  localparam logic [STEP_ANGLE_W-1:0] STEP_ANGLE_RST = 19'd450;
  localparam logic [TICK_PER_W-1:0]   TICK_PER_RST   = 8'd2;
  localparam logic [TICK_PER_W-1:0]   TICK_PER_MIN   = 8'd2;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_MOVE = 2'd1,
    CMD_STEP = 2'd2,
    CMD_SET  = 2'd3
  } cmd_t;

endpackage

/* src/sas_ifs.sv */
// command and result channel interfaces
interface sas_in_if #(
  parameter int ANGLE_BITS = sas_pkg::ANGLE_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  sas_pkg::cmd_t                       cmd;
  logic signed [ANGLE_BITS-1:0]        target_angle;
  logic                                direction;
  logic [sas_pkg::STEP_CNT_W-1:0]      step_count;

  modport source (output valid, cmd, target_angle, direction, step_count, input ready);
  modport sink (input valid, cmd, target_angle, direction, step_count, output ready);
endinterface

interface sas_out_if #(
  parameter int ANGLE_BITS = sas_pkg::ANGLE_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [sas_pkg::COIL_W-1:0]     coil_drive;
  logic                           busy_res;
  logic signed [ANGLE_BITS-1:0]   position;
  logic                           rejected;

  modport source (output valid, coil_drive, busy_res, position, rejected, input ready);
  modport sink (input valid, coil_drive, busy_res, position, rejected, output ready);
endinterface

/* src/sas_divider.sv */
// restoring divider, one quotient bit per cycle, saturated 32-bit quotient
module sas_divider #(
  parameter int DIVIDEND_BITS = sas_pkg::ANGLE_BITS_DEF + 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [DIVIDEND_BITS-1:0]          dividend,
  input  logic [sas_pkg::STEP_ANGLE_W-1:0]  divisor,
  output logic                              done,
  output logic [sas_pkg::STEPS_W-1:0]       quotient
);
  import sas_pkg::*;

  localparam int QUOT_W = (DIVIDEND_BITS > STEPS_W) ? DIVIDEND_BITS : STEPS_W;
  localparam int CNT_W  = $clog2(QUOT_W + 1);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [QUOT_W-1:0]         quot;
  logic [STEP_ANGLE_W-1:0]   rem;
  logic [STEP_ANGLE_W-1:0]   dsr;

  logic [STEP_ANGLE_W:0]     trial;
  logic [STEP_ANGLE_W:0]     trial_sub;
  logic                      fits;

  assign trial     = {rem, quot[QUOT_W-1]};
  assign fits      = trial >= {1'b0, dsr};
  assign trial_sub = trial - {1'b0, dsr};

  // a zero divisor always fits, so the quotient comes out all ones
  assign quotient = (quot > QUOT_W'({STEPS_W{1'b1}})) ? {STEPS_W{1'b1}} : quot[STEPS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W);
        quot <= QUOT_W'(dividend);
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        quot <= {quot[QUOT_W-2:0], fits};
        rem  <= fits ? trial_sub[STEP_ANGLE_W-1:0] : trial[STEP_ANGLE_W-1:0];
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/stepper_angle_step_sequencer_unit.sv */
// Two-coil bipolar stepper sequencer: tick, set-position, raw-step and rejected commands and
// a move with stepping disabled give their result word in the cycle after acceptance; a move
// with stepping enabled runs a restoring divider one quotient bit per cycle, then gives its
// result word, and the command channel is not ready meanwhile. A new command is taken while
// the previous result word is being taken. Every command gives exactly one result word.
// There is no clearing pass after reset.
module stepper_angle_step_sequencer_unit #(
  parameter int ANGLE_BITS = sas_pkg::ANGLE_BITS_DEF,
  parameter int TICK_BITS  = sas_pkg::TICK_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  sas_in_if.sink                         in_ch,
  sas_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [sas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sas_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sas_pkg::*;

  localparam int DIFF_BITS = ANGLE_BITS + 1;
  localparam int TCMP_W    = (TICK_BITS > TICK_PER_W) ? TICK_BITS : TICK_PER_W;
  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  typedef enum logic {S_IDLE, S_DIV} state_t;

  state_t                        state;

  logic [STEP_ANGLE_W-1:0]       step_angle;
  logic [TICK_PER_W-1:0]         tick_per_step;
  logic                          hold;

  logic signed [ANGLE_BITS-1:0]  position;
  logic [STEPS_W-1:0]            steps_left;
  logic [1:0]                    phase_index;
  logic                          move_reverse;
  logic [TICK_BITS-1:0]          tick_counter;
  logic [COIL_W-1:0]             coil_levels;
  logic                          moving;
  logic                          pend_rev;

  logic                          out_valid;

  logic signed [ANGLE_BITS-1:0]  position_next;
  logic [STEPS_W-1:0]            steps_left_next;
  logic [1:0]                    phase_index_next;
  logic                          move_reverse_next;
  logic [TICK_BITS-1:0]          tick_counter_next;
  logic [COIL_W-1:0]             coil_levels_next;
  logic                          moving_next;
  logic                          rejected_next;
  logic                          out_load;

  logic                          st_en;
  logic                          st_rev;
  logic [STEPS_W-1:0]            st_cnt;

  logic                          in_fire;
  logic                          step_on;
  logic [TICK_BITS-1:0]          tick_inc;
  logic                          tick_end;
  logic                          target_above;
  logic [DIFF_BITS-1:0]          diff;
  logic [STEPS_W-1:0]            div_quot;
  logic                          div_start;
  logic                          div_done;

  function automatic logic [COIL_W-1:0] drive_phase(input logic [COIL_W-1:0] levels,
                                                    input logic rev, input logic [1:0] ph);
    logic                coil_b;
    logic [1:0]          pat;
    logic [COIL_W-1:0]   res;
    coil_b = ph[0] ^ rev;
    pat    = (ph[1] ^ rev) ? 2'b10 : 2'b01;
    res    = levels;
    if (coil_b) begin
      res[3:2] = pat;
    end else begin
      res[1:0] = pat;
    end
    return res;
  endfunction

  assign in_ch.ready = (state == S_IDLE) && (!out_valid || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign step_on     = tick_per_step >= TICK_PER_MIN;

  assign tick_inc = (tick_counter == TICK_MAX) ? tick_counter : tick_counter + 1'b1;
  assign tick_end = (TCMP_W'(tick_inc) >= TCMP_W'(tick_per_step)) || (tick_inc == TICK_MAX);

  assign target_above = in_ch.target_angle > position;
  assign diff = target_above
              ? DIFF_BITS'(DIFF_BITS'(in_ch.target_angle) - DIFF_BITS'(position))
              : DIFF_BITS'(DIFF_BITS'(position) - DIFF_BITS'(in_ch.target_angle));

  sas_divider #(
    .DIVIDEND_BITS (DIFF_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .divisor  (step_angle),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    position_next     = position;
    steps_left_next   = steps_left;
    phase_index_next  = phase_index;
    move_reverse_next = move_reverse;
    tick_counter_next = tick_counter;
    coil_levels_next  = coil_levels;
    moving_next       = moving;
    rejected_next     = 1'b0;
    out_load          = 1'b0;
    div_start         = 1'b0;
    st_en             = 1'b0;
    st_rev            = 1'b0;
    st_cnt            = '0;

    if (in_fire) begin
      if (in_ch.cmd == CMD_TICK) begin
        out_load = 1'b1;
        if (moving) begin
          if (tick_end) begin
            tick_counter_next = '0;
            steps_left_next   = steps_left - 1'b1;
            if (steps_left == STEPS_W'(1)) begin
              moving_next = 1'b0;
              if (!hold) begin
                coil_levels_next = '0;
              end
            end else begin
              phase_index_next = phase_index + 2'd1;
              coil_levels_next = drive_phase(coil_levels, move_reverse, phase_index + 2'd1);
            end
          end else begin
            tick_counter_next = tick_inc;
          end
        end
      end else if (moving) begin
        rejected_next = 1'b1;
        out_load      = 1'b1;
      end else if (in_ch.cmd == CMD_MOVE) begin
        position_next = in_ch.target_angle;
        if (step_on) begin
          div_start = 1'b1;
        end else begin
          out_load = 1'b1;
        end
      end else if (in_ch.cmd == CMD_STEP) begin
        out_load = 1'b1;
        if (step_on) begin
          st_en  = 1'b1;
          st_rev = in_ch.direction;
          st_cnt = STEPS_W'(in_ch.step_count);
        end
      end else begin
        position_next = in_ch.target_angle;
        out_load      = 1'b1;
      end
    end

    if (div_done) begin
      st_en    = 1'b1;
      st_rev   = pend_rev;
      st_cnt   = div_quot;
      out_load = 1'b1;
    end

    // every move and raw step starts at phase 0
    if (st_en) begin
      move_reverse_next = st_rev;
      phase_index_next  = 2'd0;
      tick_counter_next = '0;
      if (st_cnt == '0) begin
        if (!hold) begin
          coil_levels_next = '0;
        end
      end else begin
        steps_left_next  = st_cnt;
        moving_next      = 1'b1;
        coil_levels_next = drive_phase(coil_levels, st_rev, 2'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      step_angle    <= STEP_ANGLE_RST;
      tick_per_step <= TICK_PER_RST;
      hold          <= 1'b1;
      position      <= '0;
      steps_left    <= '0;
      phase_index   <= '0;
      move_reverse  <= 1'b0;
      tick_counter  <= '0;
      coil_levels   <= '0;
      moving        <= 1'b0;
      pend_rev      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STEP_ANGLE: step_angle    <= cfg_data;
          CFG_TICK_PER:   tick_per_step <= cfg_data[TICK_PER_W-1:0];
          CFG_HOLD:       hold          <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (div_start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (div_start) begin
        pend_rev <= !target_above;
      end

      position     <= position_next;
      steps_left   <= steps_left_next;
      phase_index  <= phase_index_next;
      move_reverse <= move_reverse_next;
      tick_counter <= tick_counter_next;
      coil_levels  <= coil_levels_next;
      moving       <= moving_next;

      // result word register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.coil_drive <= coil_levels_next;
      out_ch.busy_res   <= moving_next;
      out_ch.position   <= position_next;
      out_ch.rejected   <= rejected_next;
    end
  end

  assign out_ch.valid = out_valid;

  a_div_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> !in_ch.ready)
    else $error("command taken while dividing");

  a_done_only_dividing: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside a move");

  a_moving_has_steps: assert property (@(posedge clk) disable iff (rst)
    moving |-> (steps_left != '0))
    else $error("moving with no steps left");

  a_no_coil_short: assert property (@(posedge clk) disable iff (rst)
    !(coil_levels[0] && coil_levels[1]) && !(coil_levels[2] && coil_levels[3]))
    else $error("both pins of a coil driven high");

  a_result_not_lost: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |-> !out_load)
    else $error("result word overwritten before taken");

endmodule
